// ===== hdl/fixtv_pkg.sv =====
package fixtv_pkg;

   localparam int STRING_CAPACITY = 32;
   localparam int TAG_KEY_BYTES = 4;
   localparam int SLOT_COUNT = 8;
   localparam int KEY_WIDTH = 32;

   localparam int SLOT_WIDTH = $clog2(SLOT_COUNT);
   localparam int LEN_WIDTH = $clog2(STRING_CAPACITY);
   localparam int TAG_CNT_WIDTH = $clog2(TAG_KEY_BYTES + 1);
   localparam int INDEX_WIDTH = 5;
   localparam int CSR_INDEX_WIDTH = 4;

   // Result queue: room for two words of one byte plus words still waiting on rsp_.
   localparam int QDEPTH = 4;
   localparam int QPTR = $clog2(QDEPTH);

   localparam logic [7:0] SOH_BYTE = 8'h01;
   localparam logic [7:0] EQ_BYTE = 8'h3D;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;

   localparam logic [LEN_WIDTH-1:0] STRING_LIMIT = LEN_WIDTH'(STRING_CAPACITY - 1);
   localparam logic [TAG_CNT_WIDTH-1:0] TAG_LIMIT = TAG_CNT_WIDTH'(TAG_KEY_BYTES);

   localparam logic [KEY_WIDTH-1:0] KEY_RESET [SLOT_COUNT] = '{
      32'd13619, 32'd12593, 32'd14131, 32'd13621,
      32'd14387, 32'd14643, 32'd3159345, 32'd12342
   };

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_FIELD = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLS_CHAR,
      CLS_STRING,
      CLS_DECIMAL
   } slot_class_type;

   typedef struct packed {
      kind_type                kind;
      logic [SLOT_WIDTH-1:0]   slot;
      logic [INDEX_WIDTH-1:0]  index;
      logic [31:0]             data;
      logic                    status;
      logic                    eom;
   } result_type;

   function automatic slot_class_type slot_class(input logic [SLOT_WIDTH-1:0] slot);
      slot_class_type cls;
      unique case (slot)
         3'd0, 3'd5, 3'd6: cls = CLS_CHAR;
         3'd4:             cls = CLS_DECIMAL;
         default:          cls = CLS_STRING;
      endcase
      return cls;
   endfunction

endpackage

// ===== hdl/fix_tag_value_field_extractor_unit.sv =====
// Results of an accepted byte are written into the registered result queue that drives rsp_.
// Throughput: one byte per cycle while req_tready is high; a byte that causes two results takes two
// entries of the result queue, so req_tready drops only when fewer than two queue entries are free.
// Reset: synchronous, active high; clears parse state and the result queue and
// restores the eight tag keys to their default values.
module fix_tag_value_field_extractor_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // byte_value
   input  logic                                 req_tlast,   // last_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // field_slot[2:0], byte_index[7:3], data_value[39:8], parse_status[40], zero fill
   output logic [47:0]                          rsp_tdata,
   output logic [1:0]                           rsp_tuser,   // result_kind
   output logic                                 rsp_tlast,   // end_of_message
   input  logic                                 csr_write_enable,
   input  logic [fixtv_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                          csr_write_data
);
   import fixtv_pkg::*;

   logic [KEY_WIDTH-1:0]     key_ff [SLOT_COUNT];
   logic                     value_phase_ff, value_phase_in;
   logic [KEY_WIDTH-1:0]     tag_key_ff, tag_key_in;
   logic [TAG_CNT_WIDTH-1:0] tag_cnt_ff, tag_cnt_in;
   logic                     skip_ff, skip_in;
   logic [SLOT_WIDTH-1:0]    slot_ff, slot_in;
   logic [LEN_WIDTH-1:0]     len_ff, len_in;
   logic [31:0]              acc_ff, acc_in;

   result_type               queue_ff [QDEPTH];
   logic [QPTR-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [QPTR:0]            count_ff, count_in;

   result_type               res0, res1;
   logic [1:0]               nres;
   logic                     accept, pop, err;
   logic                     match_found;
   logic [SLOT_WIDTH-1:0]    match_slot;
   logic [63:0]              shifted;
   logic [7:0]               digit;

   assign accept = req_tvalid && req_tready;
   assign pop = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= (QPTR+1)'(QDEPTH - 2));

   // Lowest-numbered equal slot wins.
   always_comb begin
      match_found = 1'b0;
      match_slot = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (key_ff[i] == tag_key_ff) begin
            match_found = 1'b1;
            match_slot = SLOT_WIDTH'(i);
         end
      end
   end

   always_comb begin
      value_phase_in = value_phase_ff;
      tag_key_in = tag_key_ff;
      tag_cnt_in = tag_cnt_ff;
      skip_in = skip_ff;
      slot_in = slot_ff;
      len_in = len_ff;
      acc_in = acc_ff;
      res0 = '0;
      res1 = '0;
      nres = 2'd0;
      err = 1'b0;
      shifted = {56'd0, req_tdata} << {tag_cnt_ff, 3'b000};
      digit = req_tdata - DIGIT_ZERO;

      if (!value_phase_ff) begin
         if (req_tdata == EQ_BYTE) begin
            skip_in = !match_found;
            slot_in = match_slot;
            value_phase_in = 1'b1;
            len_in = '0;
            acc_in = '0;
         end else if (tag_cnt_ff < TAG_LIMIT) begin
            tag_key_in = tag_key_ff | shifted[KEY_WIDTH-1:0];
            tag_cnt_in = tag_cnt_ff + 1'b1;
         end
         err = req_tlast;
      end else begin
         if (skip_ff) begin
            if (req_tdata == SOH_BYTE) begin
               value_phase_in = 1'b0;
            end
         end else begin
            unique case (slot_class(slot_ff))
               CLS_CHAR: begin
                  if (len_ff == '0) begin
                     res0.kind = KIND_BYTE;
                     res0.slot = slot_ff;
                     res0.data = {24'd0, req_tdata};
                     nres = 2'd1;
                     len_in = LEN_WIDTH'(1);
                  end else if (req_tdata == SOH_BYTE) begin
                     res0.kind = KIND_FIELD;
                     res0.slot = slot_ff;
                     res0.data = 32'd1;
                     nres = 2'd1;
                     value_phase_in = 1'b0;
                  end
               end
               CLS_DECIMAL: begin
                  if (req_tdata == SOH_BYTE) begin
                     res0.kind = KIND_FIELD;
                     res0.slot = slot_ff;
                     res0.data = acc_ff;
                     nres = 2'd1;
                     value_phase_in = 1'b0;
                  end else begin
                     acc_in = (acc_ff << 3) + (acc_ff << 1) + {24'd0, digit};
                  end
               end
               default: begin
                  if (req_tdata == SOH_BYTE) begin
                     res0.kind = KIND_FIELD;
                     res0.slot = slot_ff;
                     res0.data = 32'(len_ff);
                     nres = 2'd1;
                     value_phase_in = 1'b0;
                  end else if (len_ff < STRING_LIMIT) begin
                     res0.kind = KIND_BYTE;
                     res0.slot = slot_ff;
                     res0.index = len_ff[INDEX_WIDTH-1:0];
                     res0.data = {24'd0, req_tdata};
                     nres = 2'd1;
                     len_in = len_ff + 1'b1;
                  end
               end
            endcase
            err = req_tlast && value_phase_in;
         end
      end

      // Leaving the value phase starts a fresh tag.
      if (value_phase_ff && !value_phase_in) begin
         tag_key_in = '0;
         tag_cnt_in = '0;
         skip_in = 1'b1;
         slot_in = '0;
         len_in = '0;
         acc_in = '0;
      end

      if (req_tlast) begin
         if (nres == 2'd0) begin
            res0.kind = KIND_END;
            res0.status = err;
            res0.eom = 1'b1;
         end else begin
            res1.kind = KIND_END;
            res1.status = err;
            res1.eom = 1'b1;
         end
         nres = nres + 2'd1;
         value_phase_in = 1'b0;
         tag_key_in = '0;
         tag_cnt_in = '0;
         skip_in = 1'b1;
         slot_in = '0;
         len_in = '0;
         acc_in = '0;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = count_in + (QPTR+1)'(nres);
      end
      if (pop) begin
         count_in = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            key_ff[i] <= KEY_RESET[i];
         end
      end else if (csr_write_enable && (csr_index < CSR_INDEX_WIDTH'(SLOT_COUNT))) begin
         key_ff[csr_index[SLOT_WIDTH-1:0]] <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_phase_ff <= 1'b0;
         tag_key_ff <= '0;
         tag_cnt_ff <= '0;
         skip_ff <= 1'b1;
         slot_ff <= '0;
         len_ff <= '0;
         acc_ff <= '0;
      end else if (accept) begin
         value_phase_ff <= value_phase_in;
         tag_key_ff <= tag_key_in;
         tag_cnt_ff <= tag_cnt_in;
         skip_ff <= skip_in;
         slot_ff <= slot_in;
         len_ff <= len_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR'(nres);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (nres != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (accept && (nres == 2'd2)) begin
         queue_ff[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast = queue_ff[rd_ptr_ff].eom;
   assign rsp_tdata = {7'd0, queue_ff[rd_ptr_ff].status, queue_ff[rd_ptr_ff].data,
                       queue_ff[rd_ptr_ff].index, queue_ff[rd_ptr_ff].slot};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR+1)'(QDEPTH))
      else $error("result queue count exceeds depth");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> (count_ff + (QPTR+1)'(nres) <= (QPTR+1)'(QDEPTH)))
      else $error("byte accepted without room for its results");

   a_last_has_end: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (count_ff != '0))
      else $error("last byte left no end status queued");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (!value_phase_ff && tag_cnt_ff == '0 && skip_ff))
      else $error("parse state not cleared after message end");

   a_eom_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == KIND_END))
      else $error("end of message on a result that is not an end status");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import fixtv_pkg::*;

   typedef enum logic [3:0] {
      REG_MESSAGE_TYPE,
      REG_CLIENT_ORDER,
      REG_ORDER_IDENT,
      REG_INSTRUMENT,
      REG_QUANTITY,
      REG_ORDER_STATUS,
      REG_EXEC_TYPE,
      REG_CREATION_TIME
   } key_reg_type;

   localparam int SKIP_SLOT = SLOT_COUNT;
   localparam int PICK_PRICE = SLOT_COUNT;
   localparam int PICK_OTHER = SLOT_COUNT + 1;
   localparam logic [7:0] PRICE_DIGIT = 8'h34;
   localparam int IDLE_PERCENT = 32;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT = 200000;

   // Tracks the parse state of the extractor and holds the result words it must emit.
   class fix_field_tracker;
      logic [31:0] keys [SLOT_COUNT];
      bit in_value;
      logic [31:0] key_acc;
      int unsigned tag_bytes;
      int unsigned slot_sel;
      int unsigned stored_len;
      logic [31:0] qty_acc;
      result_type pending_results [$];
      int unsigned failures;

      function new();
         foreach (keys[i]) keys[i] = KEY_RESET[i];
         failures = 0;
         restart();
      endfunction

      function void restart();
         in_value = 0;
         key_acc = '0;
         tag_bytes = 0;
         slot_sel = SKIP_SLOT;
         stored_len = 0;
         qty_acc = '0;
      endfunction

      function void set_key(int unsigned idx, logic [31:0] value);
         if (idx < SLOT_COUNT) keys[idx] = value;
      endfunction

      function void push_result(kind_type kind, int unsigned slot, int unsigned idx,
                                logic [31:0] data, bit status, bit eom);
         result_type r;
         r.kind = kind;
         r.slot = SLOT_WIDTH'(slot);
         r.index = INDEX_WIDTH'(idx);
         r.data = data;
         r.status = status;
         r.eom = eom;
         pending_results.push_back(r);
      endfunction

      function void take_byte(logic [7:0] b, bit last);
         bit bad;
         int unsigned hit;
         int unsigned slot;
         logic [7:0] digit;
         bad = 0;
         if (!in_value) begin
            if (b == EQ_BYTE) begin
               hit = SKIP_SLOT;
               for (int i = SLOT_COUNT - 1; i >= 0; i--)
                  if (keys[i] == key_acc) hit = i;
               slot_sel = hit;
               in_value = 1;
               stored_len = 0;
               qty_acc = '0;
            end else if (tag_bytes < TAG_KEY_BYTES) begin
               key_acc = key_acc | (32'(b) << (8 * tag_bytes));
               tag_bytes++;
            end
            bad = last;
         end else begin
            slot = slot_sel;
            if (slot >= SLOT_COUNT) begin
               if (b == SOH_BYTE) restart();
            end else if (slot == REG_MESSAGE_TYPE || slot == REG_ORDER_STATUS ||
                         slot == REG_EXEC_TYPE) begin
               // The first value byte is the char, even an SOH; the rest waits for SOH.
               if (stored_len == 0) begin
                  push_result(KIND_BYTE, slot, 0, 32'(b), 0, 0);
                  stored_len = 1;
               end else if (b == SOH_BYTE) begin
                  push_result(KIND_FIELD, slot, 0, 32'd1, 0, 0);
                  restart();
               end
            end else if (slot == REG_QUANTITY) begin
               if (b == SOH_BYTE) begin
                  push_result(KIND_FIELD, slot, 0, qty_acc, 0, 0);
                  restart();
               end else begin
                  digit = b - DIGIT_ZERO;
                  qty_acc = qty_acc * 32'd10 + 32'(digit);
               end
            end else begin
               if (b == SOH_BYTE) begin
                  push_result(KIND_FIELD, slot, 0, 32'(stored_len), 0, 0);
                  restart();
               end else if (stored_len < STRING_CAPACITY - 1) begin
                  push_result(KIND_BYTE, slot, stored_len, 32'(b), 0, 0);
                  stored_len++;
               end
            end
            bad = last && in_value && slot_sel < SLOT_COUNT;
         end
         if (last) begin
            push_result(KIND_END, 0, 0, '0, bad, 1);
            restart();
         end
      endfunction

      function void compare_field(string what, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            failures++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word, kind %0h slot %0h data %0h", $time,
                     got.kind, got.slot, got.data);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("slot", 32'(want.slot), 32'(got.slot));
         compare_field("index", 32'(want.index), 32'(got.index));
         compare_field("data", want.data, got.data);
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("end flag", 32'(want.eom), 32'(got.eom));
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0] csr_write_data = '0;

   fix_field_tracker tracker = new();
   logic [8:0] message_bytes [$];   // {last, byte}
   bit calm = 0;
   int unsigned cycles = 0;

   fix_tag_value_field_extractor_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      result_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.take_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            seen.kind = kind_type'(rsp_tuser);
            seen.slot = rsp_tdata[2:0];
            seen.index = rsp_tdata[7:3];
            seen.data = rsp_tdata[39:8];
            seen.status = rsp_tdata[40];
            seen.eom = rsp_tlast;
            tracker.check_result(seen);
         end
      end
   end

   function automatic void push_byte(logic [7:0] b, bit last = 0);
      message_bytes.push_back({last, b});
   endfunction

   function automatic void push_ascii(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic logic [7:0] filler(bit no_eq);
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == SOH_BYTE || (no_eq && b == EQ_BYTE));
      return b;
   endfunction

   function automatic logic [31:0] random_key();
      logic [31:0] k;
      int unsigned n;
      k = '0;
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) k[8*i +: 8] = filler(1);
      return k;
   endfunction

   // A configured key becomes a tag of its bytes up to the highest nonzero one.
   function automatic void add_tag(int pick);
      logic [31:0] k;
      int unsigned n;
      if (pick == PICK_PRICE) begin
         push_byte(PRICE_DIGIT);
         push_byte(PRICE_DIGIT);
      end else if (pick == PICK_OTHER) begin
         n = $urandom_range(5, 1);
         repeat (n) push_byte(filler(1));
      end else begin
         k = tracker.keys[pick];
         n = 0;
         for (int i = 0; i < 4; i++) if (k[8*i +: 8] != 0) n = i + 1;
         for (int i = 0; i < n; i++) push_byte(k[8*i +: 8]);
         // Bytes past the fourth are not part of the key.
         if (n == 4 && $urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) push_byte(filler(1));
      end
   endfunction

   function automatic void add_value(int pick);
      if (pick == REG_MESSAGE_TYPE || pick == REG_ORDER_STATUS || pick == REG_EXEC_TYPE) begin
         push_byte(($urandom_range(7) == 0) ? SOH_BYTE : filler(0));
         repeat ($urandom_range(2)) push_byte(filler(0));
      end else if (pick == REG_QUANTITY) begin
         repeat ($urandom_range(10)) begin
            if ($urandom_range(5) == 0) push_byte(filler(0));
            else push_byte(DIGIT_ZERO + 8'($urandom_range(9)));
         end
      end else if (pick < SLOT_COUNT) begin
         if ($urandom_range(7) == 0) repeat ($urandom_range(40, 28)) push_byte(filler(0));
         else repeat ($urandom_range(8)) push_byte(filler(0));
      end else begin
         repeat ($urandom_range(6)) push_byte(filler(0));
      end
   endfunction

   // Mostly well-formed messages; some are cut short at a random byte, a few are noise.
   function automatic void add_message();
      int unsigned start;
      int unsigned cut;
      int unsigned roll;
      int pick;
      start = message_bytes.size();
      if ($urandom_range(19) == 0) begin
         repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(5, 1)) begin
            roll = $urandom_range(99);
            if (roll < 70) pick = $urandom_range(SLOT_COUNT - 1);
            else if (roll < 85) pick = PICK_PRICE;
            else pick = PICK_OTHER;
            add_tag(pick);
            push_byte(EQ_BYTE);
            add_value(pick);
            push_byte(SOH_BYTE);
         end
         if ($urandom_range(99) < 15) begin
            cut = $urandom_range(message_bytes.size() - 1, start);
            while (message_bytes.size() > cut + 1) void'(message_bytes.pop_back());
         end
      end
      message_bytes[message_bytes.size() - 1][8] = 1'b1;
   endfunction

   function automatic void fill_messages(int unsigned target);
      while (message_bytes.size() < target) add_message();
   endfunction

   task automatic send_stream(int unsigned calm_words);
      foreach (message_bytes[i]) begin
         calm = (i < calm_words);
         if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= message_bytes[i][7:0];
         req_tlast <= message_bytes[i][8];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      calm = 0;
      message_bytes.delete();
   endtask

   // A word that completes no field may still be in flight, so wait out the settle time as well.
   task automatic wait_drained();
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      tracker.set_key(idx, value);
   endtask

   task automatic write_keys(logic [31:0] values [SLOT_COUNT]);
      for (int r = 0; r < SLOT_COUNT; r++) write_key(CSR_INDEX_WIDTH'(r), values[r]);
      // Indexes past the last key must leave every key alone.
      write_key(CSR_INDEX_WIDTH'(SLOT_COUNT + $urandom_range(SLOT_COUNT - 1)), $urandom());
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [31:0] keys [SLOT_COUNT];
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Char that is an SOH, a decimal with a non-digit, a skipped price,
      // an end inside a string value, an end inside a tag and on '='.
      push_ascii("35=");
      push_byte(SOH_BYTE);
      push_byte(8'hFF);
      push_byte(SOH_BYTE);
      push_ascii("38=9");
      push_byte(8'h00);
      push_byte(SOH_BYTE);
      push_ascii("44=");
      push_byte(SOH_BYTE);
      push_ascii("11=");
      push_byte(8'hFF, 1);
      push_byte(8'h35, 1);
      push_byte(EQ_BYTE, 1);
      push_ascii("150=F");
      push_byte(SOH_BYTE, 1);
      fill_messages(190);
      send_stream(0);
      wait_drained();

      // Extreme keys, with a duplicate so that the lower slot must win.
      foreach (keys[i]) keys[i] = random_key();
      keys[REG_MESSAGE_TYPE] = '0;
      keys[REG_CLIENT_ORDER] = '1;
      keys[REG_ORDER_IDENT] = '0;
      keys[REG_QUANTITY] = '1;
      write_keys(keys);
      fill_messages(150);
      send_stream(110);
      wait_drained();

      foreach (keys[i]) keys[i] = random_key();
      keys[REG_ORDER_STATUS] = keys[REG_INSTRUMENT];
      write_keys(keys);
      fill_messages(180);
      send_stream(0);
      wait_drained();

      if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
